// ===== design/fmlt_pkg.sv =====
// ----------------------------------------------------------------------------
// fmlt_pkg: shared types and constants
// Word codes, configuration indexes and stage enables for the s15.16
// matrix interpolation block.
// ----------------------------------------------------------------------------
package fmlt_pkg;

  localparam int unsigned ELEM_W   = 32;  // s15.16 element
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned THR_SQ_W = 2 * THR_W;
  localparam int unsigned PROD_W   = 50;  // 32 x 18 signed product
  localparam int unsigned SQ_W     = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Word positions that carry the translation column.
  localparam logic [IDX_W-1:0] WORD_TRANS_XY = 3'd6;
  localparam logic [IDX_W-1:0] WORD_TRANS_Z  = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LERP_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TELE_THRESH = 2'd1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd32768;
  localparam logic [WEIGHT_W:0]   WCOMP_RESET  = 17'd32768;
  localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = 30'd90000;  // 300 squared

  // Load enables for the two lane stages.
  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_en_t;

endpackage

// ===== design/fmlt_req_if.sv =====
// ----------------------------------------------------------------------------
// fmlt_req_if: request channel
// Carries one word pair of the previous and the current matrix.
// ----------------------------------------------------------------------------
interface fmlt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  word_index;
  logic [31:0] prev_int_word;
  logic [31:0] prev_frac_word;
  logic [31:0] cur_int_word;
  logic [31:0] cur_frac_word;

  modport source (
    output valid, word_index, prev_int_word, prev_frac_word, cur_int_word, cur_frac_word,
    input  ready
  );
  modport sink (
    input  valid, word_index, prev_int_word, prev_frac_word, cur_int_word, cur_frac_word,
    output ready
  );
endinterface

// ===== design/fmlt_res_if.sv =====
// ----------------------------------------------------------------------------
// fmlt_res_if: result channel
// Carries one interpolated word pair with the teleport and last flags.
// ----------------------------------------------------------------------------
interface fmlt_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_int_word;
  logic [31:0] out_frac_word;
  logic        teleport;
  logic        last;

  modport source (
    output valid, out_int_word, out_frac_word, teleport, last,
    input  ready
  );
  modport sink (
    input  valid, out_int_word, out_frac_word, teleport, last,
    output ready
  );
endinterface

// ===== design/fmlt_lane.sv =====
// ----------------------------------------------------------------------------
// fmlt_lane: one element lane
// Blends one s15.16 element pair and squares its delta over two stages.
// ----------------------------------------------------------------------------
module fmlt_lane (
  input  logic                                clk_i,
  input  fmlt_pkg::pipe_en_t                  en_i,
  input  logic signed [fmlt_pkg::ELEM_W-1:0]  prev_i,
  input  logic signed [fmlt_pkg::ELEM_W-1:0]  cur_i,
  input  logic [fmlt_pkg::WEIGHT_W-1:0]       weight_i,
  input  logic [fmlt_pkg::WEIGHT_W:0]         wcomp_i,
  output logic [fmlt_pkg::ELEM_W-1:0]         blend_o,
  output logic [fmlt_pkg::SQ_W-1:0]           sq_o
);

  localparam int unsigned PROD_W = fmlt_pkg::PROD_W;
  localparam int unsigned ELEM_W = fmlt_pkg::ELEM_W;

  logic signed [fmlt_pkg::PROD_W-1:0] prod_p_d, prod_p_q;
  logic signed [fmlt_pkg::PROD_W-1:0] prod_c_d, prod_c_q;
  logic signed [fmlt_pkg::ELEM_W:0]   delta;
  logic [fmlt_pkg::ELEM_W:0]          delta_abs;
  logic [fmlt_pkg::ELEM_W-1:0]        mag_d, mag_q;
  logic signed [fmlt_pkg::PROD_W-1:0] acc;
  logic [fmlt_pkg::ELEM_W-1:0]        blend_d, blend_q;
  logic [fmlt_pkg::SQ_W-1:0]          sq_d, sq_q;

  // Stage 1: both weighted products and the delta magnitude.
  always_comb begin
    prod_p_d  = PROD_W'(prev_i) * $signed({1'b0, wcomp_i});
    prod_c_d  = PROD_W'(cur_i) * $signed({2'b00, weight_i});
    delta     = {cur_i[ELEM_W-1], cur_i} - {prev_i[ELEM_W-1], prev_i};
    delta_abs = delta[ELEM_W] ? ((ELEM_W+1)'(0) - delta) : delta;
    // The magnitude never exceeds 2^32-1, so the top bit is always clear.
    mag_d     = delta_abs[ELEM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_p_q <= prod_p_d;
      prod_c_q <= prod_c_d;
      mag_q    <= mag_d;
    end
  end

  // Stage 2: sum, divide by 65536 truncating toward zero, and square.
  always_comb begin
    acc     = prod_p_q + prod_c_q;
    // A negative sum with a nonzero fraction rounds up by one toward zero.
    blend_d = acc[47:16] + ELEM_W'(acc[PROD_W-1] && (acc[15:0] != 16'd0));
    sq_d    = mag_q * mag_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      blend_q <= blend_d;
      sq_q    <= sq_d;
    end
  end

  assign blend_o = blend_q;
  assign sq_o    = sq_q;

endmodule

// ===== design/fmlt_merge.sv =====
// ----------------------------------------------------------------------------
// fmlt_merge: lane merge and output register
// Repacks the two lane results, keeps the squared translation sum and
// raises the teleport flag on the last word.
// ----------------------------------------------------------------------------
module fmlt_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [fmlt_pkg::IDX_W-1:0]        idx_i,
  input  logic [fmlt_pkg::ELEM_W-1:0]       blend1_i,
  input  logic [fmlt_pkg::ELEM_W-1:0]       blend2_i,
  input  logic [fmlt_pkg::SQ_W-1:0]         sq1_i,
  input  logic [fmlt_pkg::SQ_W-1:0]         sq2_i,
  input  logic [fmlt_pkg::THR_SQ_W-1:0]     thr_sq_i,
  output logic [fmlt_pkg::WORD_W-1:0]       int_word_o,
  output logic [fmlt_pkg::WORD_W-1:0]       frac_word_o,
  output logic                              teleport_o,
  output logic                              last_o
);

  logic [fmlt_pkg::SQ_W-1:0] sum_d, sum_q;
  logic [fmlt_pkg::SQ_W-1:0] add_a, add_b;
  logic [fmlt_pkg::SQ_W:0]   add_full;
  logic [fmlt_pkg::SQ_W-1:0] add_sat;
  logic [fmlt_pkg::SQ_W-1:0] limit;
  logic [fmlt_pkg::WORD_W-1:0] int_word_q, frac_word_q;
  logic                      teleport_d, teleport_q, last_q;

  always_comb begin
    // Word 6 starts a fresh sum; word 7 adds the z delta to it.
    add_a = (idx_i == fmlt_pkg::WORD_TRANS_XY) ? sq2_i : sum_q;
    add_b = sq1_i;
    add_full = {1'b0, add_a} + {1'b0, add_b};
    add_sat  = add_full[fmlt_pkg::SQ_W] ? '1 : add_full[fmlt_pkg::SQ_W-1:0];
    sum_d = sum_q;
    if (idx_i == fmlt_pkg::WORD_TRANS_XY || idx_i == fmlt_pkg::WORD_TRANS_Z) begin
      sum_d = add_sat;
    end
    // The threshold is in whole units, the sum in 2^-32 square units.
    limit      = {2'b00, thr_sq_i, 32'd0};
    teleport_d = (idx_i == fmlt_pkg::WORD_TRANS_Z) && (add_sat > limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (load_i) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      int_word_q  <= {blend1_i[31:16], blend2_i[31:16]};
      frac_word_q <= {blend1_i[15:0], blend2_i[15:0]};
      teleport_q  <= teleport_d;
      last_q      <= (idx_i == fmlt_pkg::WORD_TRANS_Z);
    end
  end

  assign int_word_o  = int_word_q;
  assign frac_word_o = frac_word_q;
  assign teleport_o  = teleport_q;
  assign last_o      = last_q;

endmodule

// ===== design/fixed_matrix_lerp_teleport.sv =====
// ----------------------------------------------------------------------------
// fixed_matrix_lerp_teleport: s15.16 matrix interpolation with teleport check
// Two element lanes blend one word pair per request; a merge stage repacks
// the pair and tracks the squared translation delta.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake        Payload
//  req_i     in   valid/ready      word_index, prev/cur int and frac words
//  res_o     out  valid/ready      out_int_word, out_frac_word, teleport, last
//  cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i (weight, threshold)
//
//  One request is taken every cycle while no stall holds the result channel;
//  each result passes the product, square and merge registers in turn.
//  Each stage holds its item only while the stage after it is full and
//  stalled, so an empty stage keeps accepting while a result waits.
//  Reset clears the stage valids and the squared sum and loads the config
//  registers with their default values.
// ----------------------------------------------------------------------------
module fixed_matrix_lerp_teleport (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fmlt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fmlt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  fmlt_req_if.sink                            req_i,
  fmlt_res_if.source                          res_o
);

  logic [fmlt_pkg::WEIGHT_W-1:0]  weight_q;
  logic [fmlt_pkg::WEIGHT_W:0]    wcomp_q;
  logic [fmlt_pkg::THR_SQ_W-1:0]  thr_sq_q;
  logic [fmlt_pkg::THR_W-1:0]     thr_wr;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic [fmlt_pkg::IDX_W-1:0] idx1_q, idx2_q;
  fmlt_pkg::pipe_en_t en;

  logic signed [fmlt_pkg::ELEM_W-1:0] prev1, prev2, cur1, cur2;
  logic [fmlt_pkg::ELEM_W-1:0] blend1, blend2;
  logic [fmlt_pkg::SQ_W-1:0]   sq1, sq2;

  // Config registers; the blend complement and the squared threshold are
  // formed at write time so they stay off the datapath.
  assign thr_wr = cfg_data_i[fmlt_pkg::THR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= fmlt_pkg::WEIGHT_RESET;
      wcomp_q  <= fmlt_pkg::WCOMP_RESET;
      thr_sq_q <= fmlt_pkg::THR_SQ_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fmlt_pkg::CFG_LERP_WEIGHT: begin
          weight_q <= cfg_data_i[fmlt_pkg::WEIGHT_W-1:0];
          wcomp_q  <= 17'h10000 - {1'b0, cfg_data_i[fmlt_pkg::WEIGHT_W-1:0]};
        end
        fmlt_pkg::CFG_TELE_THRESH: begin
          thr_sq_q <= fmlt_pkg::THR_SQ_W'(thr_wr) * fmlt_pkg::THR_SQ_W'(thr_wr);
        end
        default: begin
        end
      endcase
    end
  end

  // Stage control: a stage loads when it is empty or its successor moves.
  assign rdy3 = !v3_q || res_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign req_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) idx1_q <= req_i.word_index;
    if (rdy2) idx2_q <= idx1_q;
  end

  // Unpack: high halves go to the first element, low halves to the second.
  assign prev1 = {req_i.prev_int_word[31:16], req_i.prev_frac_word[31:16]};
  assign prev2 = {req_i.prev_int_word[15:0],  req_i.prev_frac_word[15:0]};
  assign cur1  = {req_i.cur_int_word[31:16],  req_i.cur_frac_word[31:16]};
  assign cur2  = {req_i.cur_int_word[15:0],   req_i.cur_frac_word[15:0]};

  fmlt_lane u_lane1 (
    .clk_i    (clk_i),
    .en_i     (en),
    .prev_i   (prev1),
    .cur_i    (cur1),
    .weight_i (weight_q),
    .wcomp_i  (wcomp_q),
    .blend_o  (blend1),
    .sq_o     (sq1)
  );

  fmlt_lane u_lane2 (
    .clk_i    (clk_i),
    .en_i     (en),
    .prev_i   (prev2),
    .cur_i    (cur2),
    .weight_i (weight_q),
    .wcomp_i  (wcomp_q),
    .blend_o  (blend2),
    .sq_o     (sq2)
  );

  fmlt_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (rdy3 && v2_q),
    .idx_i       (idx2_q),
    .blend1_i    (blend1),
    .blend2_i    (blend2),
    .sq1_i       (sq1),
    .sq2_i       (sq2),
    .thr_sq_i    (thr_sq_q),
    .int_word_o  (res_o.out_int_word),
    .frac_word_o (res_o.out_frac_word),
    .teleport_o  (res_o.teleport),
    .last_o      (res_o.last)
  );

  assign res_o.valid = v3_q;

endmodule

// ===== bench/tb_fixed_matrix_lerp_teleport.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_matrix_lerp_teleport: self-checking bench for the matrix blender
// Streams word pairs of s15.16 matrices through the block under random
// stalls on both channels. A scoreboard class predicts every interpolated
// word and teleport flag and compares each result in order. The register
// settings change between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_fixed_matrix_lerp_teleport;
  import fmlt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [THR_W-1:0]     THRESH_RESET = 15'd300;
  localparam longint ONE_UNIT           = 65536;
  localparam int     N_PHASES           = 8;
  localparam int     MATRICES_PER_PHASE = 19;
  localparam int     MAX_REPORTS        = 10;

  typedef struct packed {
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] prev_int;
    logic [WORD_W-1:0] prev_frac;
    logic [WORD_W-1:0] cur_int;
    logic [WORD_W-1:0] cur_frac;
  } word_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_int;
    logic [WORD_W-1:0] out_frac;
    logic              teleport;
    logic              last;
  } word_res_t;

  class lerp_scoreboard;
    logic [WEIGHT_W-1:0] weight;
    logic [THR_W-1:0]    thresh;
    logic [SQ_W-1:0]     trans_sq;
    word_res_t           expected_words[$];
    int                  mismatches;

    function new();
      weight     = WEIGHT_RESET;
      thresh     = THRESH_RESET;
      trans_sq   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LERP_WEIGHT: weight = data[WEIGHT_W-1:0];
        CFG_TELE_THRESH: thresh = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Division of a signed longint truncates toward zero, as required.
    function longint blend(logic [ELEM_W-1:0] p, logic [ELEM_W-1:0] c);
      longint t;
      longint ps;
      longint cs;
      t  = longint'(weight);
      ps = longint'($signed(p));
      cs = longint'($signed(c));
      return (ps * (ONE_UNIT - t) + cs * t) / ONE_UNIT;
    endfunction

    function logic [SQ_W-1:0] square_delta(logic [ELEM_W-1:0] p, logic [ELEM_W-1:0] c);
      longint          d;
      logic [SQ_W-1:0] m;
      d = longint'($signed(c)) - longint'($signed(p));
      m = (d < 0) ? -d : d;
      return m * m;
    endfunction

    function logic [SQ_W-1:0] sat_add(logic [SQ_W-1:0] a, logic [SQ_W-1:0] b);
      logic [SQ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
    endfunction

    function void note_request(word_req_t r);
      logic [ELEM_W-1:0] p1, p2, c1, c2, o1, o2;
      longint            b1, b2;
      logic [SQ_W-1:0]   lim;
      word_res_t         e;
      p1 = {r.prev_int[31:16], r.prev_frac[31:16]};
      p2 = {r.prev_int[15:0],  r.prev_frac[15:0]};
      c1 = {r.cur_int[31:16],  r.cur_frac[31:16]};
      c2 = {r.cur_int[15:0],   r.cur_frac[15:0]};
      b1 = blend(p1, c1);
      b2 = blend(p2, c2);
      o1 = b1[31:0];
      o2 = b2[31:0];
      e.teleport = 1'b0;
      if (r.word_index == WORD_TRANS_XY) begin
        trans_sq = sat_add(square_delta(p1, c1), square_delta(p2, c2));
      end else if (r.word_index == WORD_TRANS_Z) begin
        trans_sq = sat_add(trans_sq, square_delta(p1, c1));
        // Compare against the squared threshold scaled to 2^-32 square units.
        lim = thresh;
        lim = (lim * lim) << 32;
        e.teleport = (trans_sq > lim);
      end
      e.out_int  = {o1[31:16], o2[31:16]};
      e.out_frac = {o1[15:0],  o2[15:0]};
      e.last     = (r.word_index == WORD_TRANS_Z);
      expected_words.push_back(e);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void check_result(word_res_t got);
      word_res_t e;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with no request outstanding: int %h frac %h tp %b last %b",
                   got.out_int, got.out_frac, got.teleport, got.last);
        return;
      end
      e = expected_words.pop_front();
      if (got.out_int !== e.out_int || got.out_frac !== e.out_frac ||
          got.teleport !== e.teleport || got.last !== e.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: exp int %h frac %h tp %b last %b, got int %h frac %h tp %b last %b",
                   e.out_int, e.out_frac, e.teleport, e.last,
                   got.out_int, got.out_frac, got.teleport, got.last);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    send_quiet;
  bit                    recv_quiet;
  lerp_scoreboard        sb;

  fmlt_req_if req_if ();
  fmlt_res_if res_if ();

  fixed_matrix_lerp_teleport dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Sends one word pair given as four elements; returns with valid still high.
  task automatic send_elems(input logic [IDX_W-1:0] idx,
                            input logic [ELEM_W-1:0] p1, input logic [ELEM_W-1:0] p2,
                            input logic [ELEM_W-1:0] c1, input logic [ELEM_W-1:0] c2);
    int        gap;
    word_req_t r;
    r.word_index = idx;
    r.prev_int   = {p1[31:16], p2[31:16]};
    r.prev_frac  = {p1[15:0],  p2[15:0]};
    r.cur_int    = {c1[31:16], c2[31:16]};
    r.cur_frac   = {c1[15:0],  c2[15:0]};
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.word_index     <= r.word_index;
    req_if.prev_int_word  <= r.prev_int;
    req_if.prev_frac_word <= r.prev_frac;
    req_if.cur_int_word   <= r.cur_int;
    req_if.cur_frac_word  <= r.cur_frac;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(r);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem();
    logic [ELEM_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
      3:       v = $urandom() & 32'hFFFF_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // One well-formed matrix; the translation column is shaped so that the
  // distance often lands right on or near the current threshold.
  task automatic send_matrix();
    longint            span;
    longint            d;
    int                nudge;
    int unsigned       tmode;
    int unsigned       axis;
    logic [ELEM_W-1:0] pb[3];
    logic [ELEM_W-1:0] cb[3];
    span  = longint'(sb.thresh) * ONE_UNIT;
    tmode = $urandom_range(0, 3);
    axis  = $urandom_range(0, 2);
    for (int a = 0; a < 3; a++) begin
      if (tmode == 0) begin
        pb[a] = rand_elem();
        cb[a] = rand_elem();
      end else begin
        nudge = int'($urandom_range(0, 4)) - 2;
        if (tmode == 1)
          d = 0;
        else if (tmode == 2)
          d = (a == axis) ? span + nudge : 0;
        else
          d = longint'($urandom_range(0, 32'(2 * span))) - span;
        pb[a] = $urandom_range(0, 65535) - 32768;
        cb[a] = 32'(longint'($signed(pb[a])) + d);
      end
    end
    send_quiet = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < 8; k++) begin
      if (3'(k) == WORD_TRANS_XY)
        send_elems(3'(k), pb[0], pb[1], cb[0], cb[1]);
      else if (3'(k) == WORD_TRANS_Z)
        send_elems(3'(k), pb[2], rand_elem(), cb[2], rand_elem());
      else
        send_elems(3'(k), rand_elem(), rand_elem(), rand_elem(), rand_elem());
    end
  endtask

  initial begin
    logic [WEIGHT_W-1:0] phase_weight[N_PHASES];
    logic [THR_W-1:0]    phase_thr[N_PHASES];
    longint              span;
    phase_weight = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'd65535, 16'd0, 16'd0, 16'd0};
    phase_thr    = '{15'd0, 15'd32767, 15'd300, 15'd1, 15'd0, 15'd32767, 15'd0, 15'd0};
    for (int i = N_PHASES - 2; i < N_PHASES; i++) begin
      phase_weight[i] = $urandom_range(0, 65535);
      phase_thr[i]    = $urandom_range(0, 32767);
    end
    sb = new();
    send_quiet             = 1'b0;
    rst_ni                <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= '0;
    cfg_data              <= '0;
    req_if.valid          <= 1'b0;
    req_if.word_index     <= '0;
    req_if.prev_int_word  <= '0;
    req_if.prev_frac_word <= '0;
    req_if.cur_int_word   <= '0;
    req_if.cur_frac_word  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: z word before any xy word, then a z word on its own
    // that crosses the threshold from an empty sum.
    send_elems(WORD_TRANS_Z, '0, '0, '0, '0);
    send_elems(WORD_TRANS_Z, '0, '0, 32'(301 * ONE_UNIT), '0);
    send_elems(3'd0, '0, '0, '0, '0);
    send_elems(3'd1, '1, '1, '1, '1);
    send_elems(3'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_elems(3'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    // Largest deltas saturate the squared sum.
    send_elems(WORD_TRANS_XY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_elems(WORD_TRANS_Z, 32'h7FFF_FFFF, '0, 32'h8000_0000, '1);
    // The xy word reloads the sum rather than adding to it.
    send_elems(WORD_TRANS_XY, '0, '0, '0, '0);
    send_elems(WORD_TRANS_Z, '0, '0, '0, '0);
    send_elems(WORD_TRANS_XY, '0, '0, 32'(THRESH_RESET * ONE_UNIT), '0);
    send_elems(WORD_TRANS_Z, '0, '0, '0, '0);
    send_elems(WORD_TRANS_XY, '0, '0, 32'(THRESH_RESET * ONE_UNIT), '0);
    send_elems(WORD_TRANS_Z, '0, '0, 32'd1, '0);
    send_elems(3'd4, $urandom(), $urandom(), $urandom(), $urandom());
    send_elems(3'd5, $urandom(), $urandom(), $urandom(), $urandom());
    send_elems(WORD_TRANS_XY, 32'(100 * ONE_UNIT), 32'(-50 * ONE_UNIT),
               32'(-100 * ONE_UNIT), 32'(150 * ONE_UNIT));
    send_elems(WORD_TRANS_Z, '0, $urandom(), 32'(-100 * ONE_UNIT - 1), $urandom());

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      cfg_write(CFG_LERP_WEIGHT, phase_weight[ph]);
      cfg_write(CFG_TELE_THRESH, {1'($urandom_range(0, 1)), phase_thr[ph]});
      cfg_write(ph[0] ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom()));
      send_quiet = 1'b0;
      // Distance exactly at the threshold, then one step beyond it.
      span = longint'(sb.thresh) * ONE_UNIT;
      send_elems(WORD_TRANS_XY, '0, '0, 32'(span), '0);
      send_elems(WORD_TRANS_Z, '0, $urandom(), '0, $urandom());
      send_elems(WORD_TRANS_XY, '0, '0, '0, 32'(span));
      send_elems(WORD_TRANS_Z, '0, $urandom(), 32'd1, $urandom());
      for (int m = 0; m < MATRICES_PER_PHASE; m++) begin
        if ($urandom_range(0, 5) == 0)
          send_elems(3'($urandom_range(0, 7)), rand_elem(), rand_elem(), rand_elem(),
                     rand_elem());
        send_matrix();
      end
    end

    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int        gap;
    int        taken;
    word_res_t got;
    taken         = 0;
    recv_quiet    = 1'b0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      gap = recv_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      got.out_int  = res_if.out_int_word;
      got.out_frac = res_if.out_frac_word;
      got.teleport = res_if.teleport;
      got.last     = res_if.last;
      sb.check_result(got);
      taken++;
    end
  end

endmodule

// ===== filelist.f =====
design/fmlt_pkg.sv
design/fmlt_req_if.sv
design/fmlt_res_if.sv
design/fmlt_lane.sv
design/fmlt_merge.sv
design/fixed_matrix_lerp_teleport.sv
bench/tb_fixed_matrix_lerp_teleport.sv
